// ===== rtl/core/mmbd_pkg.sv =====
package mmbd_pkg;

   localparam int BINS   = 8192;
   localparam int IDX_W  = $clog2(BINS);
   localparam int END_W  = 31;
   localparam int PROD_W = END_W + IDX_W;
   localparam int CNT_W  = $clog2(PROD_W + 1);
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(BINS - 1);

   typedef struct packed {
      logic signed [31:0] tick;
      logic signed [31:0] value;
   } point_type;

   typedef struct packed {
      point_type        pt;
      logic             final_point;
      logic [IDX_W-1:0] bin;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

// ===== rtl/core/mmbd_if.sv =====
interface mmbd_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sample_tick;
   logic signed [31:0] sample_value;
   logic               final_point;

   modport source(output valid, sample_tick, sample_value, final_point, input ready);
   modport sink(input valid, sample_tick, sample_value, final_point, output ready);
endinterface

interface mmbd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_tick;
   logic signed [31:0] out_value;
   logic               run_last;

   modport source(output valid, out_tick, out_value, run_last, input ready);
   modport sink(input valid, out_tick, out_value, run_last, output ready);
endinterface

// ===== rtl/core/mmbd_front.sv =====
module mmbd_front import mmbd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [END_W-1:0] end_tick,
   mmbd_req_if.sink         req_chan,
   output logic             push,
   output entry_type        push_data,
   input  q_stat_type       q_stat
);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_MUL  = 2'd1;
   localparam logic [1:0] F_DIV  = 2'd2;
   localparam logic [1:0] F_PUSH = 2'd3;

   logic [1:0]        st_ff, st_in;
   point_type         pt_ff;
   logic              fin_ff;
   logic [END_W-1:0]  t_ff;
   logic [END_W-1:0]  div_ff;
   logic [END_W-1:0]  rem_ff, rem_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic [END_W:0]    sh;
   logic [END_W:0]    diff;
   logic              ge;
   logic              accept;

   assign req_chan.ready = (st_ff == F_IDLE);
   assign accept = req_chan.valid && req_chan.ready;

   // one quotient bit per cycle, restoring
   always_comb begin
      sh   = {rem_ff, prod_ff[PROD_W-1]};
      diff = sh - {1'b0, div_ff};
      ge   = (sh >= {1'b0, div_ff});
   end

   always_comb begin
      st_in   = st_ff;
      rem_in  = rem_ff;
      prod_in = prod_ff;
      cnt_in  = cnt_ff;
      case (st_ff)
         F_IDLE: begin
            if (accept) st_in = F_MUL;
         end
         F_MUL: begin
            prod_in = PROD_W'(t_ff) * PROD_W'(LAST_BIN);
            rem_in  = '0;
            cnt_in  = CNT_W'(PROD_W);
            st_in   = F_DIV;
         end
         F_DIV: begin
            rem_in  = ge ? diff[END_W-1:0] : sh[END_W-1:0];
            prod_in = {prod_ff[PROD_W-2:0], ge};
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) st_in = F_PUSH;
         end
         F_PUSH: begin
            if (!q_stat.full) st_in = F_IDLE;
         end
         default: st_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= F_IDLE;
      end else begin
         st_ff <= st_in;
      end
      rem_ff  <= rem_in;
      prod_ff <= prod_in;
      cnt_ff  <= cnt_in;
      if (accept) begin
         pt_ff.tick  <= req_chan.sample_tick;
         pt_ff.value <= req_chan.sample_value;
         fin_ff      <= req_chan.final_point;
         t_ff        <= req_chan.sample_tick[31] ? '0 : req_chan.sample_tick[END_W-1:0];
         div_ff      <= (end_tick == '0) ? END_W'(1) : end_tick;
      end
   end

   assign push                  = (st_ff == F_PUSH) && !q_stat.full;
   assign push_data.pt          = pt_ff;
   assign push_data.final_point = fin_ff;
   assign push_data.bin         = (prod_ff > PROD_W'(LAST_BIN)) ? LAST_BIN
                                                                : prod_ff[IDX_W-1:0];

endmodule

// ===== rtl/core/mmbd_fifo.sv =====
module mmbd_fifo import mmbd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  entry_type  push_data,
   input  logic       pop,
   output entry_type  pop_data,
   output q_stat_type q_stat
);

   entry_type         mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QPTR_W:0]   cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + QPTR_W'(1);
         if (pop)  rd_ff <= rd_ff + QPTR_W'(1);
         if (push && !pop)      cnt_ff <= cnt_ff + (QPTR_W+1)'(1);
         else if (pop && !push) cnt_ff <= cnt_ff - (QPTR_W+1)'(1);
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end

   assign pop_data     = mem_ff[rd_ff];
   assign q_stat.full  = (cnt_ff == (QPTR_W+1)'(QDEPTH));
   assign q_stat.empty = (cnt_ff == '0);

endmodule

// ===== rtl/core/mmbd_back.sv =====
module mmbd_back import mmbd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  entry_type  pop_data,
   input  q_stat_type q_stat,
   output logic       pop,
   mmbd_rsp_if.source rsp_chan
);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_SORT = 2'd1;
   localparam logic [1:0] B_EMIT = 2'd2;

   logic [1:0]       st_ff;
   logic             bin_open_ff;
   logic [IDX_W-1:0] open_bin_ff;
   point_type        first_ff, min_ff, max_ff, last_ff;
   point_type        snap_ff [4];
   point_type        sorted_ff [4];
   logic [3:0]       dup_ff;
   logic [1:0]       last_pos_ff, pos_ff;
   logic             final_pend_ff;

   logic             out_v_ff;
   point_type        out_pt_ff;
   logic             out_last_ff;

   point_type        p, nfirst, nmin, nmax;
   logic             chg, fresh;
   logic [1:0]       rank [4];
   logic [3:0]       dup_src;
   logic [1:0]       lpos;
   logic             skip, can_out, emit_go;

   assign pop = (st_ff == B_IDLE) && !q_stat.empty;

   always_comb begin
      p      = pop_data.pt;
      chg    = bin_open_ff && (pop_data.bin != open_bin_ff);
      fresh  = !bin_open_ff || chg;
      nfirst = fresh ? p : first_ff;
      nmin   = (fresh || ($signed(p.value) < $signed(min_ff.value))) ? p : min_ff;
      nmax   = (fresh || ($signed(max_ff.value) < $signed(p.value))) ? p : max_ff;
   end

   // stable rank by tick; an equal tick seen earlier marks a duplicate
   always_comb begin
      lpos = '0;
      for (int i = 0; i < 4; i++) begin
         rank[i]    = '0;
         dup_src[i] = 1'b0;
         for (int j = 0; j < 4; j++) begin
            if (j != i) begin
               if (($signed(snap_ff[j].tick) < $signed(snap_ff[i].tick)) ||
                   ((snap_ff[j].tick == snap_ff[i].tick) && (j < i)))
                  rank[i] = rank[i] + 2'd1;
               if ((snap_ff[j].tick == snap_ff[i].tick) && (j < i))
                  dup_src[i] = 1'b1;
            end
         end
      end
      for (int i = 0; i < 4; i++) begin
         if (!dup_src[i] && (rank[i] > lpos)) lpos = rank[i];
      end
   end

   assign skip    = dup_ff[pos_ff];
   assign can_out = !out_v_ff || rsp_chan.ready;
   assign emit_go = (st_ff == B_EMIT) && !skip && can_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= B_IDLE;
         bin_open_ff   <= 1'b0;
         open_bin_ff   <= '0;
         first_ff      <= '0;
         min_ff        <= '0;
         max_ff        <= '0;
         last_ff       <= '0;
         final_pend_ff <= 1'b0;
         out_v_ff      <= 1'b0;
      end else begin
         if (emit_go) out_v_ff <= 1'b1;
         else if (out_v_ff && rsp_chan.ready) out_v_ff <= 1'b0;
         case (st_ff)
            B_IDLE: begin
               if (pop) begin
                  first_ff    <= nfirst;
                  min_ff      <= nmin;
                  max_ff      <= nmax;
                  last_ff     <= p;
                  open_bin_ff <= fresh ? pop_data.bin : open_bin_ff;
                  bin_open_ff <= !pop_data.final_point;
                  if (chg) begin
                     snap_ff[0]    <= first_ff;
                     snap_ff[1]    <= min_ff;
                     snap_ff[2]    <= max_ff;
                     snap_ff[3]    <= last_ff;
                     final_pend_ff <= pop_data.final_point;
                     st_ff         <= B_SORT;
                  end else if (pop_data.final_point) begin
                     snap_ff[0]    <= nfirst;
                     snap_ff[1]    <= nmin;
                     snap_ff[2]    <= nmax;
                     snap_ff[3]    <= p;
                     final_pend_ff <= 1'b0;
                     st_ff         <= B_SORT;
                  end
               end
            end
            B_SORT: begin
               for (int i = 0; i < 4; i++) begin
                  sorted_ff[rank[i]] <= snap_ff[i];
                  dup_ff[rank[i]]    <= dup_src[i];
               end
               last_pos_ff <= lpos;
               pos_ff      <= '0;
               st_ff       <= B_EMIT;
            end
            B_EMIT: begin
               if (skip || can_out) begin
                  if (!skip) begin
                     out_pt_ff   <= sorted_ff[pos_ff];
                     out_last_ff <= (pos_ff == last_pos_ff) && !final_pend_ff;
                  end
                  if (pos_ff == last_pos_ff) begin
                     if (final_pend_ff) begin
                        // flush the freshly opened bin after the old one
                        snap_ff[0]    <= first_ff;
                        snap_ff[1]    <= min_ff;
                        snap_ff[2]    <= max_ff;
                        snap_ff[3]    <= last_ff;
                        final_pend_ff <= 1'b0;
                        st_ff         <= B_SORT;
                     end else begin
                        st_ff <= B_IDLE;
                     end
                  end else begin
                     pos_ff <= pos_ff + 2'd1;
                  end
               end
            end
            default: st_ff <= B_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid     = out_v_ff;
   assign rsp_chan.out_tick  = out_pt_ff.tick;
   assign rsp_chan.out_value = out_pt_ff.value;
   assign rsp_chan.run_last  = out_last_ff;

   a_sort_then_emit: assert property (@(posedge clock) disable iff (reset)
      (st_ff == B_SORT) |=> (st_ff == B_EMIT))
      else $error("sort not followed by emit");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (st_ff == B_IDLE) && !q_stat.empty)
      else $error("pop outside idle");

   a_pend_busy: assert property (@(posedge clock) disable iff (reset)
      final_pend_ff |-> (st_ff != B_IDLE))
      else $error("final flush pending while idle");

   a_last_kept: assert property (@(posedge clock) disable iff (reset)
      (st_ff == B_EMIT) |-> !dup_ff[last_pos_ff])
      else $error("last emitted position is a duplicate");

endmodule

// ===== rtl/core/min_max_bin_decimator.sv =====
// channel   | dir | signals                                         | word
// req_chan  | in  | valid ready sample_tick sample_value final_point | one point
// rsp_chan  | out | valid ready out_tick out_value run_last          | one envelope point
// csr_*     | in  | csr_we csr_wdata                                | end_tick write
//
// front: each point passes accept, multiply, a 44-step divider and a queue push, and no
//   new point is taken until the push; the serial bin divider sets the point rate
// back: pops a point from the queue while idle; for each closed bin it sorts the four
//   kept points, then emits them in tick order up to the last kept one (a dropped
//   duplicate before it still takes its step), behind a four-word queue
// reset: synchronous, clears control state; end_tick returns to 1
// stalls: the output register and the queue let front and back stall on their own
module min_max_bin_decimator import mmbd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [END_W-1:0] csr_wdata,
   mmbd_req_if.sink         req_chan,
   mmbd_rsp_if.source       rsp_chan
);

   logic [END_W-1:0] end_tick_ff;
   logic             push, pop;
   entry_type        push_data, pop_data;
   q_stat_type       q_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         end_tick_ff <= END_W'(1);
      end else if (csr_we) begin
         end_tick_ff <= csr_wdata;
      end
   end

   mmbd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .end_tick  (end_tick_ff),
      .req_chan  (req_chan),
      .push      (push),
      .push_data (push_data),
      .q_stat    (q_stat)
   );

   mmbd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_stat    (q_stat)
   );

   mmbd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_data (pop_data),
      .q_stat   (q_stat),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== sim/mmbd_checker.sv =====
module mmbd_checker import mmbd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [END_W-1:0] csr_wdata,
   mmbd_req_if.sink         req_mon,
   mmbd_rsp_if.sink         rsp_mon,
   output int               fail_count,
   output int               pending_count
);

   typedef struct {
      logic signed [31:0] tick;
      logic signed [31:0] value;
      logic               last;
   } env_word_type;

   env_word_type      env_queue[$];
   logic [END_W-1:0]  graph_end;
   logic              bin_held;
   logic [IDX_W-1:0]  held_bin;
   point_type         kept_first, kept_min, kept_max, kept_last;

   assign pending_count = env_queue.size();

   function automatic logic [IDX_W-1:0] bin_index(logic signed [31:0] tick);
      logic [63:0] t;
      logic [63:0] d;
      logic [63:0] q;
      t = (tick < 0) ? 64'd0 : 64'(tick);
      d = (graph_end == 0) ? 64'd1 : 64'(graph_end);
      q = t * 64'(BINS - 1) / d;
      if (q > 64'(BINS - 1)) q = 64'(BINS - 1);
      return q[IDX_W-1:0];
   endfunction

   task automatic push_bin();
      point_type pts[4];
      point_type k;
      env_word_type w;
      int j;
      pts[0] = kept_first; pts[1] = kept_min; pts[2] = kept_max; pts[3] = kept_last;
      // stable sort by tick
      for (int i = 1; i < 4; i++) begin
         k = pts[i];
         j = i - 1;
         while (j >= 0 && k.tick < pts[j].tick) begin
            pts[j+1] = pts[j];
            j--;
         end
         pts[j+1] = k;
      end
      for (int i = 0; i < 4; i++) begin
         if (i > 0 && pts[i].tick == pts[i-1].tick) continue;
         w.tick  = pts[i].tick;
         w.value = pts[i].value;
         w.last  = 1'b0;
         env_queue.insert(env_queue.size(), w);
      end
   endtask

   task automatic absorb_point(logic signed [31:0] tick, logic signed [31:0] value,
                               logic fin);
      logic [IDX_W-1:0] b;
      point_type p;
      int before_n;
      b = bin_index(tick);
      p.tick = tick;
      p.value = value;
      before_n = env_queue.size();
      if (bin_held && b != held_bin) begin
         push_bin();
         bin_held = 1'b0;
      end
      if (!bin_held) begin
         bin_held = 1'b1;
         held_bin = b;
         kept_first = p; kept_min = p; kept_max = p; kept_last = p;
      end else begin
         kept_last = p;
         if (value < kept_min.value) kept_min = p;
         if (kept_max.value < value) kept_max = p;
      end
      if (fin) begin
         push_bin();
         bin_held = 1'b0;
      end
      if (env_queue.size() > before_n) env_queue[env_queue.size()-1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      env_word_type e;
      if (reset) begin
         graph_end <= END_W'(1);
         bin_held = 1'b0;
         held_bin = '0;
         fail_count <= 0;
         env_queue.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (env_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected word tick %0d value %0d last %0b",
                           rsp_mon.out_tick, rsp_mon.out_value, rsp_mon.run_last);
               fail_count <= fail_count + 1;
            end else begin
               e = env_queue.pop_front();
               if (e.tick !== rsp_mon.out_tick || e.value !== rsp_mon.out_value ||
                   e.last !== rsp_mon.run_last) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
                              e.tick, e.value, e.last, rsp_mon.out_tick,
                              rsp_mon.out_value, rsp_mon.run_last);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            absorb_point(req_mon.sample_tick, req_mon.sample_value, req_mon.final_point);
         if (csr_we) graph_end <= csr_wdata;
      end
   end

endmodule

// ===== sim/testbench.sv =====
module testbench;
   import mmbd_pkg::*;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [END_W-1:0] csr_wdata;
   int               fail_count;
   int               pending_count;
   bit               hold_long;
   logic signed [31:0] tick_now;

   mmbd_req_if req_chan();
   mmbd_rsp_if rsp_chan();

   min_max_bin_decimator u_dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   mmbd_checker u_checker (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_mon(req_chan.sink), .rsp_mon(rsp_chan.sink),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("Simulation FAILED");
      $finish;
   end

   // receiver stall pattern, with one long hold-off
   initial begin
      int n;
      bit long_done;
      long_done = 1'b0;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_long && !long_done) begin
            rsp_chan.ready <= 1'b0;
            repeat (3000) @(posedge clock);
            long_done = 1'b1;
         end
         n = $urandom_range(0, 3);
         if (n == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   task automatic send_point(logic signed [31:0] tick, logic signed [31:0] value,
                             logic fin);
      req_chan.valid        <= 1'b1;
      req_chan.sample_tick  <= tick;
      req_chan.sample_value <= value;
      req_chan.final_point  <= fin;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic idle_gap();
      req_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clock);
   endtask

   task automatic write_end(int unsigned v);
      // drain, then allow for the front pipeline still at work
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= END_W'(v);
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_graph(int points, int unsigned span);
      int burst;
      tick_now = ($urandom_range(0, 9) == 0) ? -$signed(32'($urandom_range(1, 50)))
                                              : 32'($urandom_range(0, 20));
      burst = $urandom_range(1, 10);
      for (int i = 0; i < points; i++) begin
         if ($urandom_range(0, 15) == 0)
            tick_now = tick_now - 32'($urandom_range(0, 5));
         else
            tick_now = tick_now + 32'($urandom_range(0, (span >> 4) + 1));
         if ($urandom_range(0, 30) == 0) tick_now = $urandom;
         send_point(tick_now, $urandom, (i == points - 1) || ($urandom_range(0, 40) == 0));
         burst--;
         if (burst == 0) begin
            if ($urandom_range(0, 2) != 0) idle_gap();
            burst = $urandom_range(1, 10);
         end
      end
      req_chan.valid <= 1'b0;
   endtask

   initial begin
      int wait_n;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      hold_long = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.sample_tick = '0;
      req_chan.sample_value = '0;
      req_chan.final_point = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: end_tick at reset value, then zero and extremes
      send_point(32'sh8000_0000, 32'sh8000_0000, 1'b0);
      send_point(-5, 32'sh7fff_ffff, 1'b0);
      send_point(0, 0, 1'b0);
      send_point(0, 0, 1'b1);
      send_point(1, 32'sh7fff_ffff, 1'b0);
      send_point(32'sh7fff_ffff, 32'sh8000_0000, 1'b1);
      write_end(0);
      send_point(0, 10, 1'b0);
      send_point(1, 10, 1'b0);
      send_point(2, 5, 1'b1);
      write_end(31'h7fff_ffff);
      send_point(100, 3, 1'b0);
      send_point(90, 1, 1'b0);
      send_point(100, 9, 1'b0);
      send_point(80, 9, 1'b0);
      send_point(85, 1, 1'b0);
      send_point(32'sh7fff_ffff, -1, 1'b0);
      send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1);
      write_end(1000);
      send_point(10, 4, 1'b0);
      send_point(11, 2, 1'b0);
      send_point(12, 8, 1'b0);
      send_point(13, 6, 1'b0);
      send_point(500, 1, 1'b0);
      write_end(8191);
      send_point(600, 7, 1'b1);

      // long hold-off while the sender keeps offering
      write_end(100);
      hold_long = 1'b1;
      random_graph(30, 100);

      write_end(5000);
      random_graph(110, 5000);
      write_end(1);
      random_graph(40, 1);
      write_end(31'h7fff_ffff);
      random_graph(40, 31'h7fff_ffff);
      write_end($urandom_range(2, 1 << 20));
      random_graph(110, 1 << 16);
      write_end(0);
      random_graph(30, 0);

      @(posedge clock);
      wait_n = 0;
      while (pending_count != 0 && wait_n < 200000) begin
         @(posedge clock);
         wait_n++;
      end
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
